@@ rtl/core/jpeg_bit_reader_unstuff_defines.svh @@
// Assertion helpers shared by the bit reader modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef JPEG_BIT_READER_UNSTUFF_DEFINES_SVH
`define JPEG_BIT_READER_UNSTUFF_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define JBRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define JBRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/jbru_pkg.sv @@
package jbru_pkg;

	localparam int BUF_BITS = 64;
	localparam int MAX_READ = 32;

	localparam int FILL_W = $clog2(BUF_BITS + 1);
	localparam int TAKE_W = $clog2(MAX_READ + 1);

	localparam int ACTION_W = 2;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_END  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_STUFF   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd3;

	localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [BYTE_W-1:0]   data_byte;
		logic [COUNT_W-1:0]  bit_count;
		logic                skip_stuffing;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic [COUNT_W-1:0]  bits_delivered;
		logic [STATUS_W-1:0] status;
		logic                stream_finished;
	} result_t;

endpackage

@@ rtl/core/jbru_item_if.sv @@
interface jbru_item_if;
	logic                               valid;
	logic                               ready;
	logic [jbru_pkg::ACTION_W-1:0]      action;
	logic [jbru_pkg::BYTE_W-1:0]        data_byte;
	logic [jbru_pkg::COUNT_W-1:0]       bit_count;
	logic                               skip_stuffing;

	modport source (output valid, action, data_byte, bit_count, skip_stuffing, input ready);
	modport sink (input valid, action, data_byte, bit_count, skip_stuffing, output ready);
endinterface

@@ rtl/core/jbru_result_if.sv @@
interface jbru_result_if;
	logic                               valid;
	logic                               ready;
	logic [jbru_pkg::VALUE_W-1:0]       read_value;
	logic [jbru_pkg::COUNT_W-1:0]       bits_delivered;
	logic [jbru_pkg::STATUS_W-1:0]      status;
	logic                               stream_finished;

	modport source (output valid, read_value, bits_delivered, status, stream_finished,
		input ready);
	modport sink (input valid, read_value, bits_delivered, status, stream_finished,
		output ready);
endinterface

@@ rtl/core/jbru_bitbuf.sv @@
`include "jpeg_bit_reader_unstuff_defines.svh"

module jbru_bitbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  jbru_pkg::item_t  item,
	input  logic             fire,
	output jbru_pkg::result_t res
);

	// The oldest buffered bit sits at the top of bits_q; unused bits are zero.
	logic [jbru_pkg::BUF_BITS-1:0] bits_q;
	logic [jbru_pkg::FILL_W-1:0]   fill_q;
	logic                          last_ff_q;
	logic                          ended_q;

	logic [jbru_pkg::BUF_BITS-1:0] bits_nx;
	logic [jbru_pkg::FILL_W-1:0]   fill_nx;
	logic                          last_ff_nx;
	logic                          ended_nx;

	logic [jbru_pkg::TAKE_W-1:0]   want;
	logic [jbru_pkg::TAKE_W-1:0]   take;
	logic [jbru_pkg::TAKE_W-1:0]   drop_amt;
	logic                          short_fill;
	logic                          stuffed;
	logic                          full;
	logic [jbru_pkg::MAX_READ-1:0] window;
	logic [jbru_pkg::MAX_READ-1:0] read_bits;
	logic [jbru_pkg::BUF_BITS-1:0] load_bits;

	always_comb begin
		if ({1'b0, item.bit_count} > (jbru_pkg::COUNT_W + 1)'(jbru_pkg::MAX_READ)) begin
			want = jbru_pkg::TAKE_W'(jbru_pkg::MAX_READ);
		end else begin
			want = item.bit_count[jbru_pkg::TAKE_W-1:0];
		end
		short_fill = jbru_pkg::FILL_W'(want) > fill_q;
		if (!short_fill) begin
			take = want;
		end else if (ended_q) begin
			// Fewer bits than asked remain, and all of them fit in a read.
			take = fill_q[jbru_pkg::TAKE_W-1:0];
		end else begin
			take = '0;
		end
		drop_amt  = jbru_pkg::TAKE_W'(jbru_pkg::MAX_READ) - take;
		window    = bits_q[jbru_pkg::BUF_BITS-1 -: jbru_pkg::MAX_READ];
		read_bits = window >> drop_amt;

		load_bits = {item.data_byte, (jbru_pkg::BUF_BITS - jbru_pkg::BYTE_W)'(0)} >> fill_q;
		stuffed   = item.skip_stuffing && last_ff_q && (item.data_byte == jbru_pkg::BYTE_ZERO);
		full      = ({1'b0, fill_q} + (jbru_pkg::FILL_W + 1)'(jbru_pkg::BYTE_W))
			> (jbru_pkg::FILL_W + 1)'(jbru_pkg::BUF_BITS);

		bits_nx    = bits_q;
		fill_nx    = fill_q;
		last_ff_nx = last_ff_q;
		ended_nx   = ended_q;
		res.read_value     = '0;
		res.bits_delivered = '0;
		res.status         = jbru_pkg::ST_DONE;

		unique case (item.action)
			jbru_pkg::ACT_LOAD: begin
				if (ended_q) begin
					res.status = jbru_pkg::ST_REFUSED;
				end else if (stuffed) begin
					last_ff_nx = 1'b0;
					res.status = jbru_pkg::ST_STUFF;
				end else if (full) begin
					res.status = jbru_pkg::ST_REFUSED;
				end else begin
					bits_nx    = bits_q | load_bits;
					fill_nx    = fill_q + jbru_pkg::FILL_W'(jbru_pkg::BYTE_W);
					last_ff_nx = (item.data_byte == jbru_pkg::BYTE_FF);
				end
			end
			jbru_pkg::ACT_READ: begin
				if (short_fill) begin
					res.status = ended_q ? jbru_pkg::ST_SHORT : jbru_pkg::ST_REFUSED;
				end
				bits_nx            = bits_q << take;
				fill_nx            = fill_q - jbru_pkg::FILL_W'(take);
				res.read_value     = jbru_pkg::VALUE_W'(read_bits);
				res.bits_delivered = jbru_pkg::COUNT_W'(take);
			end
			jbru_pkg::ACT_END: begin
				ended_nx = 1'b1;
			end
			default: begin
				res.status = jbru_pkg::ST_REFUSED;
			end
		endcase
		res.stream_finished = ended_nx && (fill_nx == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q    <= '0;
			fill_q    <= '0;
			last_ff_q <= 1'b0;
			ended_q   <= 1'b0;
		end else if (fire) begin
			bits_q    <= bits_nx;
			fill_q    <= fill_nx;
			last_ff_q <= last_ff_nx;
			ended_q   <= ended_nx;
		end
	end

	`JBRU_ASSERT_NEXT(a_load_grows, fire && (item.action == jbru_pkg::ACT_LOAD) && (res.status == jbru_pkg::ST_DONE), fill_q == $past(fill_q) + jbru_pkg::FILL_W'(jbru_pkg::BYTE_W), "accepted load did not add one byte")
	`JBRU_ASSERT_NEXT(a_read_shrinks, fire && (item.action == jbru_pkg::ACT_READ), fill_q == $past(fill_q) - jbru_pkg::FILL_W'($past(res.bits_delivered)), "read did not remove the delivered bits")
	`JBRU_ASSERT_NEXT(a_end_sticks, ended_q, ended_q, "end of stream mark was lost")
	`JBRU_ASSERT_NOW(a_empty_clean, fill_q == '0, bits_q == '0, "empty buffer holds stale bits")

endmodule

@@ rtl/core/jpeg_bit_reader_unstuff.sv @@
// MSB-first bit reader with 0xFF00 byte unstuffing. Each transaction on the item
// channel loads a byte, reads 0 to 32 bits, or marks the end of the stream, and
// produces exactly one transaction on the result channel, in order. One item is
// taken per cycle while the result channel is not stalled; every item performs a
// combinational update of the bit buffer (a barrel shift of its 64 bits plus the
// fill compare). An item is registered on acceptance, and the buffer is updated
// as the item moves into the result register, from which its result is offered.
// The input register doubles as a skid stage, so one more item is taken while a
// result waits before the input stalls.
`include "jpeg_bit_reader_unstuff_defines.svh"

module jpeg_bit_reader_unstuff (
	input logic         clk,
	input logic         arst_n,
	jbru_item_if.sink   item,
	jbru_result_if.source result
);

	jbru_pkg::item_t   item_s1;
	logic              valid_s1;
	jbru_pkg::result_t res;
	jbru_pkg::result_t res_q;
	logic              res_valid_q;
	logic              out_adv;
	logic              fire;

	assign out_adv    = !res_valid_q || result.ready;
	assign fire       = valid_s1 && out_adv;
	assign item.ready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{action: item.action, data_byte: item.data_byte,
				bit_count: item.bit_count, skip_stuffing: item.skip_stuffing};
		end
	end

	jbru_bitbuf u_bitbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (fire),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.read_value      = res_q.read_value;
	assign result.bits_delivered  = res_q.bits_delivered;
	assign result.status          = res_q.status;
	assign result.stream_finished = res_q.stream_finished;

	`JBRU_ASSERT_NEXT(a_fire_gives_result, fire, res_valid_q, "processed item produced no result")
	`JBRU_ASSERT_NEXT(a_accept_loads_s1, item.valid && item.ready, valid_s1, "accepted item was not registered")
	`JBRU_ASSERT_NEXT(a_s1_holds, valid_s1 && !out_adv, valid_s1 && $stable(item_s1), "waiting item changed before it was processed")

endmodule

@@ verif/tb_jpeg_bit_reader_unstuff.sv @@
module tb_jpeg_bit_reader_unstuff;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 505;
	localparam int LONG_HOLD  = 80;
	localparam int QUIET_MAX  = 2000;
	localparam int IDLE_PCT   = 35;

	// Action code that the block does not use.
	localparam logic [jbru_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	jbru_item_if   item_ch();
	jbru_result_if result_ch();

	jpeg_bit_reader_unstuff DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	jbru_pkg::item_t   pending_items[$];
	jbru_pkg::result_t expected_results[$];

	int  items_taken;
	int  results_seen;
	int  error_count;
	int  quiet_cycles;
	int  hold_left;
	bit  long_hold_done;
	bit  item_took;

	// Shadow copy of the block's state used to predict each result.
	logic [jbru_pkg::BUF_BITS-1:0] shadow_bits;
	int                            shadow_fill;
	bit                            shadow_after_ff;
	bit                            shadow_ended;

	// Both sides stop idling for a while so back-to-back traffic is seen too.
	wire calm = (items_taken >= 200) && (items_taken < 330);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic jbru_pkg::result_t predict_result(jbru_pkg::item_t it);
		jbru_pkg::result_t             r;
		int                            take;
		logic [jbru_pkg::BUF_BITS-1:0] fresh;
		r = '0;
		r.status = jbru_pkg::ST_DONE;
		case (it.action)
			jbru_pkg::ACT_LOAD: begin
				if (shadow_ended) begin
					r.status = jbru_pkg::ST_REFUSED;
				end else if (it.skip_stuffing && shadow_after_ff &&
						it.data_byte == jbru_pkg::BYTE_ZERO) begin
					shadow_after_ff = 1'b0;
					r.status = jbru_pkg::ST_STUFF;
				end else if (shadow_fill + jbru_pkg::BYTE_W > jbru_pkg::BUF_BITS) begin
					r.status = jbru_pkg::ST_REFUSED;
				end else begin
					fresh = {it.data_byte, {(jbru_pkg::BUF_BITS - jbru_pkg::BYTE_W){1'b0}}};
					shadow_bits = shadow_bits | (fresh >> shadow_fill);
					shadow_fill += jbru_pkg::BYTE_W;
					shadow_after_ff = (it.data_byte == jbru_pkg::BYTE_FF);
				end
			end
			jbru_pkg::ACT_READ: begin
				take = (it.bit_count > jbru_pkg::MAX_READ) ? jbru_pkg::MAX_READ
					: int'(it.bit_count);
				if (take > shadow_fill) begin
					if (shadow_ended) begin
						take = shadow_fill;
						r.status = jbru_pkg::ST_SHORT;
					end else begin
						take = 0;
						r.status = jbru_pkg::ST_REFUSED;
					end
				end
				if (take > 0) begin
					r.read_value = jbru_pkg::VALUE_W'(shadow_bits >> (jbru_pkg::BUF_BITS - take));
					shadow_bits = shadow_bits << take;
					shadow_fill -= take;
				end
				r.bits_delivered = jbru_pkg::COUNT_W'(take);
			end
			jbru_pkg::ACT_END: begin
				shadow_ended = 1'b1;
			end
			default: begin
				r.status = jbru_pkg::ST_REFUSED;
			end
		endcase
		r.stream_finished = shadow_ended && (shadow_fill == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: result %0d: %s", $realtime, results_seen, msg);
		error_count++;
	endtask

	task automatic queue_item(input logic [jbru_pkg::ACTION_W-1:0] action,
		input logic [jbru_pkg::BYTE_W-1:0] data,
		input logic [jbru_pkg::COUNT_W-1:0] count, input logic skip);
		jbru_pkg::item_t it;
		it.action = action;
		it.data_byte = data;
		it.bit_count = count;
		it.skip_stuffing = skip;
		pending_items.push_back(it);
	endtask

	// Mostly well-formed loads and reads, with 0xFF 0x00 pairs mixed in and a little noise.
	// Unused fields carry random junk so every input bit toggles.
	task automatic queue_random_item(inout int n);
		int                           pick;
		int                           sz;
		logic [jbru_pkg::COUNT_W-1:0] junk_count;
		logic [jbru_pkg::BYTE_W-1:0]  junk_byte;
		pick = $urandom_range(0, 99);
		junk_count = jbru_pkg::COUNT_W'($urandom);
		junk_byte = jbru_pkg::BYTE_W'($urandom);
		if (pick < 4) begin
			queue_item(ACT_UNUSED, junk_byte, junk_count, 1'($urandom));
			n += 1;
		end else if (pick < 18) begin
			queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_FF, junk_count,
				1'($urandom_range(0, 9) < 8));
			queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_ZERO, junk_count,
				1'($urandom_range(0, 9) < 8));
			n += 2;
		end else if (pick < 60) begin
			queue_item(jbru_pkg::ACT_LOAD, junk_byte, junk_count, 1'($urandom_range(0, 9) < 8));
			n += 1;
		end else begin
			sz = $urandom_range(0, 99);
			if (sz < 8)
				junk_count = '0;
			else if (sz < 18)
				junk_count = jbru_pkg::COUNT_W'($urandom_range(jbru_pkg::MAX_READ + 1, 63));
			else
				junk_count = jbru_pkg::COUNT_W'($urandom_range(1, jbru_pkg::MAX_READ));
			queue_item(jbru_pkg::ACT_READ, junk_byte, junk_count, 1'($urandom));
			n += 1;
		end
	endtask

	task automatic wait_all_done();
		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Sender: offers the oldest pending item and holds it until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (item_ch.valid && !item_took) begin
			item_ch.valid <= 1'b1;
		end else if (pending_items.size() != 0 &&
				(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
			item_ch.valid         <= 1'b1;
			item_ch.action        <= pending_items[0].action;
			item_ch.data_byte     <= pending_items[0].data_byte;
			item_ch.bit_count     <= pending_items[0].bit_count;
			item_ch.skip_stuffing <= pending_items[0].skip_stuffing;
		end else begin
			item_ch.valid <= 1'b0;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off so the block fills up.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && results_seen >= 120) begin
			result_ch.ready <= 1'b0;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Monitor: predicts on each accepted item and checks each accepted result.
	always @(posedge clk) begin
		jbru_pkg::item_t   it;
		jbru_pkg::result_t got;
		jbru_pkg::result_t want;
		if (arst_n) begin
			item_took <= item_ch.valid && item_ch.ready;
			if (item_ch.valid && item_ch.ready) begin
				it.action = item_ch.action;
				it.data_byte = item_ch.data_byte;
				it.bit_count = item_ch.bit_count;
				it.skip_stuffing = item_ch.skip_stuffing;
				expected_results.push_back(predict_result(it));
				void'(pending_items.pop_front());
				items_taken <= items_taken + 1;
			end
			if (result_ch.valid && result_ch.ready) begin
				got.read_value = result_ch.read_value;
				got.bits_delivered = result_ch.bits_delivered;
				got.status = result_ch.status;
				got.stream_finished = result_ch.stream_finished;
				if (expected_results.size() == 0) begin
					report_mismatch("result transaction with no item outstanding");
				end else begin
					want = expected_results.pop_front();
					if (got.read_value !== want.read_value)
						report_mismatch($sformatf("read_value got %h expected %h",
							got.read_value, want.read_value));
					if (got.bits_delivered !== want.bits_delivered)
						report_mismatch($sformatf("bits_delivered got %0d expected %0d",
							got.bits_delivered, want.bits_delivered));
					if (got.status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							got.status, want.status));
					if (got.stream_finished !== want.stream_finished)
						report_mismatch($sformatf("stream_finished got %b expected %b",
							got.stream_finished, want.stream_finished));
				end
				results_seen <= results_seen + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_MAX) begin
				$display("timeout: no transaction for %0d cycles", QUIET_MAX);
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int n;
		item_ch.valid = 1'b0;
		item_ch.action = jbru_pkg::ACT_LOAD;
		item_ch.data_byte = '0;
		item_ch.bit_count = '0;
		item_ch.skip_stuffing = 1'b0;
		result_ch.ready = 1'b0;
		items_taken = 0;
		results_seen = 0;
		error_count = 0;
		quiet_cycles = 0;
		hold_left = 0;
		long_hold_done = 1'b0;
		item_took = 1'b0;
		shadow_bits = '0;
		shadow_fill = 0;
		shadow_after_ff = 1'b0;
		shadow_ended = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty buffer: a zero-bit read succeeds, a one-bit read is refused.
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd0, 1'b0);
		queue_item(jbru_pkg::ACT_READ, 8'hFF, 6'd1, 1'b1);
		// Stuffed zero is dropped once; a second zero and an unskipped zero are kept.
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_FF, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_ZERO, 6'd63, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_ZERO, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_FF, 6'd0, 1'b0);
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_ZERO, 6'd0, 1'b0);
		// Oversized read saturates to the maximum.
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd63, 1'b0);
		// Fill the buffer to the brim, ending on 0xFF.
		queue_item(jbru_pkg::ACT_LOAD, 8'hA5, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, 8'h5A, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, 8'h00, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, 8'h80, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, 8'h01, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, 8'h7F, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, 8'hFE, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_FF, 6'd0, 1'b1);
		// Stuffing is dropped even with a full buffer; a real byte is refused.
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_ZERO, 6'd0, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, 8'h12, 6'd0, 1'b0);
		queue_item(ACT_UNUSED, 8'hC3, 6'd42, 1'b1);
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd32, 1'b0);
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd1, 1'b0);
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd31, 1'b0);
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd5, 1'b0);
		wait_all_done();

		n = 0;
		while (n < N_RANDOM)
			queue_random_item(n);
		wait_all_done();

		// End of stream: loads are refused, reads drain what is left and then run short.
		queue_item(jbru_pkg::ACT_END, 8'h00, 6'd0, 1'b0);
		queue_item(jbru_pkg::ACT_END, 8'hFF, 6'd63, 1'b1);
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_FF, 6'd0, 1'b0);
		queue_item(jbru_pkg::ACT_LOAD, jbru_pkg::BYTE_ZERO, 6'd0, 1'b1);
		repeat (12) begin
			if ($urandom_range(0, 3) == 0)
				queue_item(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom), 1'($urandom));
			else
				queue_item(jbru_pkg::ACT_READ, 8'($urandom), 6'($urandom_range(0, 63)),
					1'($urandom));
		end
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd32, 1'b0);
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd32, 1'b0);
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd7, 1'b0);
		queue_item(jbru_pkg::ACT_READ, 8'h00, 6'd0, 1'b0);
		queue_item(ACT_UNUSED, 8'h00, 6'd0, 1'b0);
		wait_all_done();
		repeat (8) @(posedge clk);

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
